// ----- rtl/wrapped_radius_class_count_nearest_unit_macros.svh -----
// Assertion macros shared by the wrapped radius class count blocks.
`ifndef WRAPPED_RADIUS_CLASS_COUNT_NEAREST_UNIT_MACROS_SVH
`define WRAPPED_RADIUS_CLASS_COUNT_NEAREST_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WRCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WRCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wrcc_pkg.sv -----
// Shared types, constants and the class lookup for the wrapped radius class counter.
package wrcc_pkg;

  localparam int unsigned ClassCount = 7;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef logic [2:0]  class_t;
  typedef logic [10:0] count_t;

  localparam count_t COUNT_MAX = 11'd2047;
  localparam logic [2:0] SITE_TYPE_NONE = 3'd7;
  localparam logic signed [3:0] NO_CLASS = -4'sd1;

  // Configuration register indexes.
  localparam logic [1:0] REG_WORLD_WIDTH   = 2'd0;
  localparam logic [1:0] REG_REACH_SQUARED = 2'd1;
  localparam logic [1:0] REG_CLASS_MAP     = 2'd2;

  localparam logic [12:0] RESET_WORLD_WIDTH = 13'd4096;
  localparam logic [31:0] RESET_REACH       = 32'd65536;
  localparam logic [20:0] RESET_CLASS_MAP   = 21'd1758760;

  // One classified site as handed from the front stages to the accumulator.
  typedef struct packed {
    logic [31:0] sq_x;
    logic [31:0] sq_y;
    class_t      cls;
    logic        first;
    logic        last;
  } site_job_t;

  function automatic class_t class_of(logic [2:0] kind, logic [20:0] map);
    class_t c;
    c = 3'd0;
    if (kind != SITE_TYPE_NONE) begin
      c = 3'(map >> (5'(kind) * 5'd3));
    end
    if (32'(c) >= ClassCount) begin
      c = 3'd0;
    end
    return c;
  endfunction

endpackage

// ----- rtl/wrcc_intf.sv -----
// Handshake channels for site beats in and result beats out.
interface wrcc_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] site_x;
  logic [11:0] site_y;
  logic [2:0]  site_type;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic        first_site;
  logic        last_site;

  modport source (output valid, site_x, site_y, site_type, center_x, center_y,
                  first_site, last_site, input ready);
  modport sink (input valid, site_x, site_y, site_type, center_x, center_y,
                first_site, last_site, output ready);
endinterface

interface wrcc_out_if import wrcc_pkg::*; ();
  logic               valid;
  logic               ready;
  count_t             count_class0;
  count_t             count_class1;
  count_t             count_class2;
  count_t             count_class3;
  count_t             count_class4;
  count_t             count_class5;
  count_t             count_class6;
  logic signed [3:0]  nearest_class;

  modport source (output valid, count_class0, count_class1, count_class2, count_class3,
                  count_class4, count_class5, count_class6, nearest_class, input ready);
  modport sink (input valid, count_class0, count_class1, count_class2, count_class3,
                count_class4, count_class5, count_class6, nearest_class, output ready);
endinterface

// ----- rtl/wrcc_front.sv -----
// Front stages: offset, horizontal wrap fold, squares and class lookup.
module wrcc_front import wrcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  wrcc_in_if.sink     item_in,
  input  logic [12:0] world_width_i,
  input  logic [20:0] class_map_i,
  output logic        push_o,
  output site_job_t   job_o,
  input  logic        full_i
);

  logic adv;
  logic s1_v_q, s2_v_q, s3_v_q;

  logic signed [17:0] dx_raw, dy_raw;
  logic [15:0]        ady_raw;

  logic signed [17:0] dx1_q;
  logic [15:0]        ady1_q;
  class_t             cls1_q;
  logic               first1_q, last1_q;

  logic signed [19:0] half, full, d0, d1, d2;
  logic [15:0]        adx;

  logic [15:0] adx2_q, ady2_q;
  class_t      cls2_q;
  logic        first2_q, last2_q;

  logic [31:0] sq_x_q, sq_y_q;
  class_t      cls3_q;
  logic        first3_q, last3_q;

  // The stages move together; they hold only when the last one cannot hand off.
  assign adv = !s3_v_q || !full_i;
  assign item_in.ready = adv;

  assign dx_raw  = $signed({1'b0, item_in.site_x, 4'b0000}) - $signed({2'b00, item_in.center_x});
  assign dy_raw  = $signed({1'b0, item_in.site_y, 4'b0000}) - $signed({2'b00, item_in.center_y});
  assign ady_raw = dy_raw[17] ? 16'(-dy_raw) : 16'(dy_raw);

  // Fold once into plus or minus half the world width, in 1/16 tile.
  assign half = $signed({4'b0000, world_width_i, 3'b000});
  assign full = $signed({3'b000, world_width_i, 4'b0000});
  assign d0   = 20'(dx1_q);
  assign d1   = (d0 > half) ? d0 - full : d0;
  assign d2   = (d1 < -half) ? d1 + full : d1;
  assign adx  = d2[19] ? 16'(-d2) : 16'(d2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= item_in.valid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx1_q    <= dx_raw;
      ady1_q   <= ady_raw;
      cls1_q   <= class_of(item_in.site_type, class_map_i);
      first1_q <= item_in.first_site;
      last1_q  <= item_in.last_site;

      adx2_q   <= adx;
      ady2_q   <= ady1_q;
      cls2_q   <= cls1_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;

      sq_x_q   <= 32'(adx2_q) * 32'(adx2_q);
      sq_y_q   <= 32'(ady2_q) * 32'(ady2_q);
      cls3_q   <= cls2_q;
      first3_q <= first2_q;
      last3_q  <= last2_q;
    end
  end

  assign push_o = s3_v_q && !full_i;
  assign job_o  = '{sq_x: sq_x_q, sq_y: sq_y_q, cls: cls3_q, first: first3_q, last: last3_q};

endmodule

// ----- rtl/wrcc_queue.sv -----
// Short queue of classified sites between the front stages and the accumulator.
`include "wrapped_radius_class_count_nearest_unit_macros.svh"

module wrcc_queue import wrcc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  site_job_t job_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output site_job_t head_o
);

  localparam logic [QueuePtrW:0] FullCount = (QueuePtrW + 1)'(QueueDepth);

  site_job_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]     cnt_q;

  assign full_o  = (cnt_q == FullCount);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `WRCC_ASSERT_IMP(a_no_pop_empty, pop_i, !empty_o, "queue popped while empty")
  `WRCC_ASSERT_NXT(a_fill_tracks, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "queue fill count did not advance on push")

endmodule

// ----- rtl/wrcc_back.sv -----
// Accumulator: reach test, per-class counts, nearest tracking and the result register.
`include "wrapped_radius_class_count_nearest_unit_macros.svh"

module wrcc_back import wrcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  site_job_t   head_i,
  input  logic        empty_i,
  output logic        pop_o,
  input  logic [31:0] reach_squared_i,
  wrcc_out_if.source  res_out
);

  count_t            cnt_q [ClassCount];
  logic [33:0]       best_q;
  logic signed [3:0] best_cls_q;

  count_t            cnt_d [ClassCount];
  logic [33:0]       best_d;
  logic signed [3:0] best_cls_d;

  logic [33:0]       site_dist, base_best;
  logic              in_reach, closer;

  logic              out_v_q;
  count_t            res_cnt_q [ClassCount];
  logic signed [3:0] res_cls_q;

  // A closing site waits while the previous result is still held.
  assign pop_o = !empty_i && (!head_i.last || !out_v_q || res_out.ready);

  assign site_dist = 34'(head_i.sq_x) + 34'(head_i.sq_y);
  assign base_best = head_i.first ? 34'(reach_squared_i) : best_q;
  assign in_reach  = site_dist <= 34'(reach_squared_i);
  assign closer    = site_dist <= base_best;

  always_comb begin
    for (int k = 0; k < ClassCount; k++) begin
      cnt_d[k] = head_i.first ? '0 : cnt_q[k];
      if (in_reach && head_i.cls == class_t'(k) && cnt_d[k] < COUNT_MAX) begin
        cnt_d[k] = cnt_d[k] + 1'b1;
      end
    end
    best_d     = base_best;
    best_cls_d = head_i.first ? NO_CLASS : best_cls_q;
    if (in_reach && closer) begin
      best_d     = site_dist;
      best_cls_d = $signed({1'b0, head_i.cls});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ClassCount; k++) begin
        cnt_q[k] <= '0;
      end
      best_q     <= 34'(RESET_REACH);
      best_cls_q <= NO_CLASS;
      out_v_q    <= 1'b0;
    end else begin
      if (pop_o) begin
        cnt_q      <= cnt_d;
        best_q     <= best_d;
        best_cls_q <= best_cls_d;
      end
      if (pop_o && head_i.last) begin
        out_v_q <= 1'b1;
      end else if (res_out.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.last) begin
      res_cnt_q <= cnt_d;
      res_cls_q <= best_cls_d;
    end
  end

  assign res_out.valid         = out_v_q;
  assign res_out.count_class0  = res_cnt_q[0];
  assign res_out.count_class1  = res_cnt_q[1];
  assign res_out.count_class2  = res_cnt_q[2];
  assign res_out.count_class3  = res_cnt_q[3];
  assign res_out.count_class4  = res_cnt_q[4];
  assign res_out.count_class5  = res_cnt_q[5];
  assign res_out.count_class6  = res_cnt_q[6];
  assign res_out.nearest_class = res_cls_q;

  `WRCC_ASSERT_NXT(a_result_loaded, pop_o && head_i.last, out_v_q, "closing site did not raise the result")
  `WRCC_ASSERT_IMP(a_nearest_legal, out_v_q, res_cls_q == NO_CLASS || $unsigned(res_cls_q) < 4'(ClassCount), "nearest class out of range")

endmodule

// ----- rtl/wrapped_radius_class_count_nearest_unit.sv -----
// A closing site's result passes the three front stages, the queue and the result register.
// One site per cycle while the queue has room; front stages, queue and accumulator each take one.
// The result register frees the front: sites keep flowing while a result waits to be taken.
// Reset is asynchronous, active low: control and config registers take their reset values,
// counts clear, the tracked nearest class is -1 and the best distance holds the reset reach.
module wrapped_radius_class_count_nearest_unit import wrcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  wrcc_in_if.sink     item_in,
  wrcc_out_if.source  res_out,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic [12:0] world_width_q;
  logic [31:0] reach_q;
  logic [20:0] class_map_q;

  logic      push, full, pop, empty;
  site_job_t job, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      world_width_q <= RESET_WORLD_WIDTH;
      reach_q       <= RESET_REACH;
      class_map_q   <= RESET_CLASS_MAP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WORLD_WIDTH:   world_width_q <= cfg_data_i[12:0];
        REG_REACH_SQUARED: reach_q       <= cfg_data_i;
        REG_CLASS_MAP:     class_map_q   <= cfg_data_i[20:0];
        default: ;
      endcase
    end
  end

  wrcc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_in      (item_in),
    .world_width_i(world_width_q),
    .class_map_i  (class_map_q),
    .push_o       (push),
    .job_o        (job),
    .full_i       (full)
  );

  wrcc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .head_o (head)
  );

  wrcc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .empty_i        (empty),
    .pop_o          (pop),
    .reach_squared_i(reach_q),
    .res_out        (res_out)
  );

endmodule
